[hw/rtl/awdt_pkg.sv]
package awdt_pkg;

    localparam int DELAY_BITS_DEFAULT = 20;
    localparam int STEP_BITS_DEFAULT  = 16;

    localparam int CFG_DELAY_W = 20;
    localparam int CFG_STEP_W  = 16;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 1;

    localparam int RETRIES_W = 4;
    localparam int TREND_W   = 8;

    localparam int RESET_DELAY = 4000;
    localparam int RESET_STEP  = 128;
    localparam int SMALL_STEP  = 4;

    localparam logic [RETRIES_W-1:0] RETRY_LIMIT = 4'd10;

    localparam logic signed [TREND_W-1:0] TREND_FLOOR = -8'sd100;
    localparam logic signed [TREND_W-1:0] TREND_UP    = 8'sd1;
    localparam logic signed [TREND_W-1:0] TREND_DOWN  = -8'sd1;
    localparam logic signed [TREND_W-1:0] TREND_ZERO  = 8'sd0;

    localparam logic OP_REPORT  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_DELAY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_STEP  = 1'b1;

    typedef struct packed {
        logic [CFG_DELAY_W-1:0] initial_delay;
        logic [CFG_STEP_W-1:0]  initial_step;
    } awdt_cfg_t;

endpackage

[hw/rtl/awdt_cfg_regs.sv]
module awdt_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [awdt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [awdt_pkg::CFG_DATA_W-1:0]     cfg_data,
    output awdt_pkg::awdt_cfg_t                 cfg
);

    logic [awdt_pkg::CFG_DELAY_W-1:0] initial_delay_reg;
    logic [awdt_pkg::CFG_DELAY_W-1:0] initial_delay_next;
    logic [awdt_pkg::CFG_STEP_W-1:0]  initial_step_reg;
    logic [awdt_pkg::CFG_STEP_W-1:0]  initial_step_next;

    always_comb
    begin
        initial_delay_next = initial_delay_reg;
        initial_step_next  = initial_step_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                awdt_pkg::REG_INITIAL_DELAY:
                begin
                    initial_delay_next = cfg_data[awdt_pkg::CFG_DELAY_W-1:0];
                end
                awdt_pkg::REG_INITIAL_STEP:
                begin
                    initial_step_next = cfg_data[awdt_pkg::CFG_STEP_W-1:0];
                end
                default:
                begin
                    initial_delay_next = initial_delay_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_delay_reg <= awdt_pkg::CFG_DELAY_W'(awdt_pkg::RESET_DELAY);
            initial_step_reg  <= awdt_pkg::CFG_STEP_W'(awdt_pkg::RESET_STEP);
        end
        else
        begin
            initial_delay_reg <= initial_delay_next;
            initial_step_reg  <= initial_step_next;
        end
    end

    assign cfg.initial_delay = initial_delay_reg;
    assign cfg.initial_step  = initial_step_reg;

endmodule

[hw/rtl/awdt_update.sv]
module awdt_update #(
    parameter int DELAY_BITS = awdt_pkg::DELAY_BITS_DEFAULT,
    parameter int STEP_BITS  = awdt_pkg::STEP_BITS_DEFAULT
) (
    input  awdt_pkg::awdt_cfg_t                       cfg,
    input  logic                                      op,
    input  logic [awdt_pkg::RETRIES_W-1:0]            retries,
    input  logic [DELAY_BITS-1:0]                     delay_cur,
    input  logic [STEP_BITS-1:0]                      step_cur,
    input  logic signed [awdt_pkg::TREND_W-1:0]       trend_cur,
    output logic [DELAY_BITS-1:0]                     delay_new,
    output logic [STEP_BITS-1:0]                      step_new,
    output logic signed [awdt_pkg::TREND_W-1:0]       trend_new
);

    localparam int SUM_W = ((DELAY_BITS > STEP_BITS) ? DELAY_BITS : STEP_BITS) + 1;
    localparam int RD_W  = (DELAY_BITS > awdt_pkg::CFG_DELAY_W) ?
                           DELAY_BITS : awdt_pkg::CFG_DELAY_W;
    localparam int RS_W  = (STEP_BITS > awdt_pkg::CFG_STEP_W) ?
                           STEP_BITS : awdt_pkg::CFG_STEP_W;

    localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;
    localparam logic [STEP_BITS-1:0]  STEP_MAX  = '1;
    localparam logic [STEP_BITS-1:0]  STEP_SMALL = STEP_BITS'(awdt_pkg::SMALL_STEP);
    localparam logic [STEP_BITS-1:0]  STEP_ONE   = STEP_BITS'(1);

    function automatic logic [SUM_W-1:0] ext_d(input logic [DELAY_BITS-1:0] v);
        return SUM_W'(v);
    endfunction

    function automatic logic [SUM_W-1:0] ext_s(input logic [STEP_BITS-1:0] v);
        return SUM_W'(v);
    endfunction

    function automatic logic [DELAY_BITS-1:0] sat_d(input logic [SUM_W-1:0] v);
        return (v > SUM_W'(DELAY_MAX)) ? DELAY_MAX : v[DELAY_BITS-1:0];
    endfunction

    function automatic logic [STEP_BITS-1:0] sat_s(input logic [SUM_W-1:0] v);
        return (v > SUM_W'(STEP_MAX)) ? STEP_MAX : v[STEP_BITS-1:0];
    endfunction

    // Halve and take one off, leaving a step of zero or one alone.
    function automatic logic [STEP_BITS-1:0] halve(input logic [STEP_BITS-1:0] s);
        return (s > STEP_ONE) ? ((s >> 1) - STEP_ONE) : s;
    endfunction

    logic [RD_W-1:0]       restart_delay_ext;
    logic [RS_W-1:0]       restart_step_ext;
    logic [DELAY_BITS-1:0] restart_delay;
    logic [STEP_BITS-1:0]  restart_step;

    assign restart_delay_ext = RD_W'(cfg.initial_delay);
    assign restart_step_ext  = RS_W'(cfg.initial_step);
    assign restart_delay = (restart_delay_ext > RD_W'(DELAY_MAX)) ?
                           DELAY_MAX : restart_delay_ext[DELAY_BITS-1:0];
    assign restart_step  = (restart_step_ext > RS_W'(STEP_MAX)) ?
                           STEP_MAX : restart_step_ext[STEP_BITS-1:0];

    always_comb
    begin
        delay_new = delay_cur;
        step_new  = step_cur;
        trend_new = trend_cur;
        if (op == awdt_pkg::OP_RESTART)
        begin
            delay_new = restart_delay;
            step_new  = restart_step;
            trend_new = awdt_pkg::TREND_ZERO;
        end
        else if (retries < awdt_pkg::RETRY_LIMIT)
        begin
            if (retries != '0)
            begin
                // Too short: trend goes up, step retuned, delay kept or longer.
                if (step_cur < STEP_SMALL)
                begin
                    step_new  = sat_s(ext_s(step_cur) + SUM_W'(1));
                    delay_new = sat_d(ext_d(delay_cur) + ext_s(step_new));
                end
                else if (trend_cur > awdt_pkg::TREND_ZERO)
                begin
                    step_new  = sat_s((ext_s(step_cur) << 1) - SUM_W'(1));
                    delay_new = sat_d(ext_d(delay_cur) + ext_s(step_new));
                end
                else if (trend_cur < awdt_pkg::TREND_ZERO)
                begin
                    delay_new = sat_d(ext_d(delay_cur) + ext_s(step_cur));
                    step_new  = halve(step_cur);
                end
                trend_new = awdt_pkg::TREND_UP;
            end
            else
            begin
                if (trend_cur < awdt_pkg::TREND_ZERO)
                begin
                    if (step_cur > STEP_ONE)
                    begin
                        step_new = sat_s((ext_s(step_cur) << 1) - SUM_W'(1));
                        if (ext_d(delay_cur) > ext_s(step_new))
                        begin
                            delay_new = DELAY_BITS'(ext_d(delay_cur) - ext_s(step_new));
                        end
                    end
                end
                else if (trend_cur > awdt_pkg::TREND_ZERO)
                begin
                    if (ext_d(delay_cur) > ext_s(step_cur))
                    begin
                        delay_new = DELAY_BITS'(ext_d(delay_cur) - ext_s(step_cur));
                    end
                    step_new  = halve(step_cur);
                    trend_new = awdt_pkg::TREND_DOWN;
                end
                // At the floor the trend stops and the step creeps up instead.
                if (trend_new > awdt_pkg::TREND_FLOOR)
                begin
                    trend_new = trend_new - awdt_pkg::TREND_UP;
                end
                else
                begin
                    step_new = sat_s(ext_s(step_new) + SUM_W'(1));
                end
            end
        end
    end

endmodule

[hw/rtl/adaptive_write_delay_tuner_unit.sv]
// A word accepted into the input register has its result word written into the
// result register once that register is free.
// Throughput: one word per cycle, sustained while the result side keeps taking words;
// the input register and the result register each hold one word, so a stalled
// output holds back the input only after both are full.
// Reset: delay 4000 us, step 128 us, trend 0, restart values 4000 us and 128 us,
// and no word held in either register.
module adaptive_write_delay_tuner_unit #(
    parameter int DELAY_BITS = awdt_pkg::DELAY_BITS_DEFAULT,
    parameter int STEP_BITS  = awdt_pkg::STEP_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [awdt_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [awdt_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    op,
    input  logic [awdt_pkg::RETRIES_W-1:0]          retries,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [DELAY_BITS-1:0]                   write_delay_us,
    output logic [STEP_BITS-1:0]                    step_us,
    output logic signed [awdt_pkg::TREND_W-1:0]     trend
);

    awdt_pkg::awdt_cfg_t cfg;

    logic                                 in_valid_reg;
    logic                                 in_valid_next;
    logic                                 op_reg;
    logic [awdt_pkg::RETRIES_W-1:0]       retries_reg;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [DELAY_BITS-1:0]                delay_reg;
    logic [DELAY_BITS-1:0]                delay_next;
    logic [STEP_BITS-1:0]                 step_reg;
    logic [STEP_BITS-1:0]                 step_next;
    logic signed [awdt_pkg::TREND_W-1:0]  trend_reg;
    logic signed [awdt_pkg::TREND_W-1:0]  trend_next;
    logic                                 in_accept;
    logic                                 advance;

    awdt_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    awdt_update #(
        .DELAY_BITS (DELAY_BITS),
        .STEP_BITS  (STEP_BITS)
    ) u_update (
        .cfg       (cfg),
        .op        (op_reg),
        .retries   (retries_reg),
        .delay_cur (delay_reg),
        .step_cur  (step_reg),
        .trend_cur (trend_reg),
        .delay_new (delay_next),
        .step_new  (step_next),
        .trend_new (trend_next)
    );

    // The tuner state doubles as the result register; it moves only when the
    // previous result word has been taken or is being taken.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            delay_reg     <= DELAY_BITS'(awdt_pkg::RESET_DELAY);
            step_reg      <= STEP_BITS'(awdt_pkg::RESET_STEP);
            trend_reg     <= awdt_pkg::TREND_ZERO;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                delay_reg <= delay_next;
                step_reg  <= step_next;
                trend_reg <= trend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg      <= op;
            retries_reg <= retries;
        end
    end

    assign out_valid      = out_valid_reg;
    assign write_delay_us = delay_reg;
    assign step_us        = step_reg;
    assign trend          = trend_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (trend_reg <= awdt_pkg::TREND_UP) && (trend_reg >= awdt_pkg::TREND_FLOOR))
        else $error("Trend left its range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
        ($stable(delay_reg) && $stable(step_reg) && $stable(trend_reg)))
        else $error("Tuner state changed while a result word was waiting.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg == awdt_pkg::OP_RESTART)) |=>
        (out_valid_reg && (trend_reg == awdt_pkg::TREND_ZERO)))
        else $error("Restart did not clear the trend.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg == awdt_pkg::OP_REPORT) && (retries_reg != '0) &&
         (retries_reg < awdt_pkg::RETRY_LIMIT)) |=>
        (trend_reg == awdt_pkg::TREND_UP))
        else $error("A retry outcome did not set the trend up.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=>
        (in_valid_reg && $stable(op_reg) && $stable(retries_reg)))
        else $error("Held input word was lost or changed.");

endmodule
